@@ rtl/smst_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// smst_pkg
// shared types, command codes and control/status bundles for the sorted
// marker set block
// -----------------------------------------------------------------------------
package smst_pkg;

  localparam int TimeW        = 48;
  localparam int MaxMarksDflt = 64;

  typedef enum logic [1:0] {
    CMD_TOGGLE = 2'd0,
    CMD_NEAR   = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_PREV   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [TimeW-1:0] time_in;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic [TimeW-1:0] mark_time;
    logic             status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, clear scan results
    logic scan;    // walk stored marks
    logic decide;  // form result, set up pointers
    logic shd_rd;  // shift down: read next entry, or drop count at end
    logic shd_wr;  // shift down: write entry, step up
    logic shu_rd;  // shift up: read previous entry
    logic shu_wr;  // shift up: write entry, step down
    logic put;     // write new mark, bump count
    logic resp;    // hand result to output register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic is_toggle;
    logic near_found;
    logic full;
    logic shd_more;
    logic shu_more;
    logic out_free;
  } sts_t;

endpackage : smst_pkg
`default_nettype wire

@@ rtl/smst_ram.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// smst_ram
// generic single-write, single-read ram with registered read data
// -----------------------------------------------------------------------------
module smst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  wire logic [Width-1:0]                 wdata_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic      [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : smst_ram
`default_nettype wire

@@ rtl/smst_ctrl.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// smst_ctrl
// sequencer: scan, decide, shift and respond for one request at a time
// -----------------------------------------------------------------------------
module smst_ctrl
  import smst_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SCAN   = 10'b00_0000_0010,
    ST_DECIDE = 10'b00_0000_0100,
    ST_SHD_RD = 10'b00_0000_1000,
    ST_SHD_WR = 10'b00_0001_0000,
    ST_SHU_RD = 10'b00_0010_0000,
    ST_SHU_WR = 10'b00_0100_0000,
    ST_PUT    = 10'b00_1000_0000,
    ST_RESP   = 10'b01_0000_0000,
    ST_SPARE  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ctl_o.decide = 1'b1;
        if (!sts_i.is_toggle) begin
          state_d = ST_RESP;
        end else if (sts_i.near_found) begin
          state_d = ST_SHD_RD;
        end else if (sts_i.full) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_SHU_RD;
        end
      end
      ST_SHD_RD: begin
        ctl_o.shd_rd = 1'b1;
        state_d      = sts_i.shd_more ? ST_SHD_WR : ST_RESP;
      end
      ST_SHD_WR: begin
        ctl_o.shd_wr = 1'b1;
        state_d      = ST_SHD_RD;
      end
      ST_SHU_RD: begin
        ctl_o.shu_rd = 1'b1;
        state_d      = sts_i.shu_more ? ST_SHU_WR : ST_PUT;
      end
      ST_SHU_WR: begin
        ctl_o.shu_wr = 1'b1;
        state_d      = ST_SHU_RD;
      end
      ST_PUT: begin
        ctl_o.put = 1'b1;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        ctl_o.resp = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands are mutually exclusive
  a_ctl_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ctl_o))
    else $error("more than one datapath command at once");

  // a request is only taken from idle and always starts a scan
  a_load_to_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> (state_q == ST_SCAN))
    else $error("load not followed by scan");

  // the sequencer never sits in the unused code
  a_no_spare : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_SPARE)
    else $error("sequencer in unused state");

endmodule : smst_ctrl
`default_nettype wire

@@ rtl/smst_dpath.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// smst_dpath
// mark storage, scan compare, shift pointers and result registers
// -----------------------------------------------------------------------------
module smst_dpath
  import smst_pkg::*;
#(
  parameter int MaxMarks = MaxMarksDflt
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire in_t              in_data_i,
  input  wire logic             cfg_we_i,
  input  wire logic [TimeW-1:0] cfg_wdata_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output out_t                  out_data_o,
  input  wire ctl_t             ctl_i,
  output sts_t                  sts_o
);

  localparam int AddrW = $clog2(MaxMarks > 1 ? MaxMarks : 2);
  localparam int CntW  = $clog2(MaxMarks + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxMarks);

  logic [TimeW-1:0] thr_q;
  logic [1:0]       cmd_q;
  logic [TimeW-1:0] time_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic             near_found_q, near_found_d;
  logic [CntW-1:0]  near_idx_q, near_idx_d;
  logic             ge_found_q, ge_found_d;
  logic [CntW-1:0]  ge_idx_q, ge_idx_d;
  logic             gt_found_q, gt_found_d;
  logic [TimeW-1:0] gt_val_q, gt_val_d;
  logic             lt_found_q, lt_found_d;
  logic [TimeW-1:0] lt_val_q, lt_val_d;
  out_t             res_q, res_d;
  out_t             out_q;
  logic             out_vld_q, out_vld_d;

  logic             ram_we;
  logic [CntW-1:0]  raddr_w;
  logic [TimeW-1:0] ram_wdata;
  logic [TimeW-1:0] rdata;

  logic [TimeW-1:0] abs_gap;
  logic             is_near, is_ge, is_gt;
  logic [CntW-1:0]  eval_idx;
  logic             out_free;

  smst_ram #(
    .Width (TimeW),
    .Depth (MaxMarks)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_w[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // read address: scan at pointer, shifts one beside it
  always_comb begin
    if (ctl_i.shd_rd) begin
      raddr_w = ptr_q + CntW'(1);
    end else if (ctl_i.shu_rd) begin
      raddr_w = ptr_q - CntW'(1);
    end else begin
      raddr_w = ptr_q;
    end
  end

  assign ram_we    = ctl_i.shd_wr | ctl_i.shu_wr | ctl_i.put;
  assign ram_wdata = ctl_i.put ? time_q : rdata;

  // compare of the entry read last cycle
  assign abs_gap  = (rdata > time_q) ? (rdata - time_q) : (time_q - rdata);
  assign is_near  = (abs_gap <= thr_q);
  assign is_ge    = (rdata >= time_q);
  assign is_gt    = (rdata > time_q);
  assign eval_idx = ptr_q - CntW'(1);

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    sts_o.scan_done  = (ptr_q >= cnt_q) && !rd_vld_q;
    sts_o.is_toggle  = (cmd_q == CMD_TOGGLE);
    sts_o.near_found = near_found_q;
    sts_o.full       = (cnt_q == CntMax);
    sts_o.shd_more   = ({1'b0, ptr_q} + (CntW+1)'(1)) < {1'b0, cnt_q};
    sts_o.shu_more   = (ptr_q > ge_idx_q);
    sts_o.out_free   = out_free;
  end

  always_comb begin
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    rd_vld_d     = 1'b0;
    near_found_d = near_found_q;
    near_idx_d   = near_idx_q;
    ge_found_d   = ge_found_q;
    ge_idx_d     = ge_idx_q;
    gt_found_d   = gt_found_q;
    gt_val_d     = gt_val_q;
    lt_found_d   = lt_found_q;
    lt_val_d     = lt_val_q;
    res_d        = res_q;

    if (ctl_i.load) begin
      ptr_d        = '0;
      near_found_d = 1'b0;
      ge_found_d   = 1'b0;
      gt_found_d   = 1'b0;
      lt_found_d   = 1'b0;
    end

    if (ctl_i.scan) begin
      if (ptr_q < cnt_q) begin
        rd_vld_d = 1'b1;
        ptr_d    = ptr_q + CntW'(1);
      end
      if (rd_vld_q) begin
        if (is_near && !near_found_q) begin
          near_found_d = 1'b1;
          near_idx_d   = eval_idx;
        end
        if (is_ge && !ge_found_q) begin
          ge_found_d = 1'b1;
          ge_idx_d   = eval_idx;
        end
        if (is_gt && !gt_found_q) begin
          gt_found_d = 1'b1;
          gt_val_d   = rdata;
        end
        // sorted, so the last one below wins
        if (!is_ge) begin
          lt_found_d = 1'b1;
          lt_val_d   = rdata;
        end
      end
    end

    if (ctl_i.decide) begin
      // insert position falls to the end when nothing is at or above
      if (!ge_found_q) begin
        ge_idx_d = cnt_q;
      end
      ptr_d = (cmd_q == CMD_TOGGLE && near_found_q) ? near_idx_q : cnt_q;
      res_d = '0;
      unique case (cmd_e'(cmd_q))
        CMD_TOGGLE: begin
          res_d.hit    = !near_found_q && (cnt_q != CntMax);
          res_d.status = !near_found_q && (cnt_q == CntMax);
        end
        CMD_NEAR: begin
          res_d.hit = near_found_q;
        end
        CMD_NEXT: begin
          res_d.hit       = gt_found_q;
          res_d.mark_time = gt_found_q ? gt_val_q : '0;
        end
        CMD_PREV: begin
          res_d.hit       = lt_found_q;
          res_d.mark_time = lt_found_q ? lt_val_q : '0;
        end
        default: begin
          res_d = '0;
        end
      endcase
    end

    if (ctl_i.shd_rd && !sts_o.shd_more) begin
      cnt_d = cnt_q - CntW'(1);
    end
    if (ctl_i.shd_wr) begin
      ptr_d = ptr_q + CntW'(1);
    end
    if (ctl_i.shu_wr) begin
      ptr_d = ptr_q - CntW'(1);
    end
    if (ctl_i.put) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    if (ctl_i.resp && out_free) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= in_data_i.cmd;
      time_q <= in_data_i.time_in;
    end
    if (ctl_i.resp && out_free) begin
      out_q <= res_q;
    end
    ptr_q        <= ptr_d;
    near_found_q <= near_found_d;
    near_idx_q   <= near_idx_d;
    ge_found_q   <= ge_found_d;
    ge_idx_q     <= ge_idx_d;
    gt_found_q   <= gt_found_d;
    gt_val_q     <= gt_val_d;
    lt_found_q   <= lt_found_d;
    lt_val_q     <= lt_val_d;
    res_q        <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("mark count above capacity");

  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CntW'(1) || cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("mark count jumped by more than one");

  a_put_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.put |-> (cnt_q < CntMax) && (ptr_q == ge_idx_q))
    else $error("new mark written to a full set or off its position");

  a_wr_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ptr_q < CntMax))
    else $error("ram write beyond capacity");

endmodule : smst_dpath
`default_nettype wire

@@ rtl/sorted_marker_set_toggle.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// sorted_marker_set_toggle
// sorted timestamp set with toggle, near, next and previous lookups
// -----------------------------------------------------------------------------
// Keeps up to MaxMarks 48-bit timestamps in ascending order in one ram
// with a registered read port. One request is worked at a time. Every
// request first walks the stored marks one per cycle; near, next and
// previous answer once the walk is done. A toggle that removes a mark
// shifts the marks above it down by one, and an insert shifts the marks
// at and above the new position up by one; each shifted entry is read
// through the single ram port pair before it is rewritten. The set is
// empty after reset with no clearing pass. The threshold register may be
// written at any cycle the block is idle; a result waits in the output
// register while the next request is taken.
// -----------------------------------------------------------------------------
module sorted_marker_set_toggle
  import smst_pkg::*;
#(
  parameter int MaxMarks = MaxMarksDflt
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_t              in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o,
  // snap threshold register
  input  wire logic             cfg_we_i,
  input  wire logic [TimeW-1:0] cfg_wdata_i
);

  ctl_t ctl;
  sts_t sts;

  // sequencer: idle, scan, decide, shift, put, respond
  smst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // storage, compares, pointers, result and output registers
  smst_dpath #(
    .MaxMarks (MaxMarks)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule : sorted_marker_set_toggle
`default_nettype wire

@@ tb/smst_tb_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// smst_tb_pkg
// result prediction and checking for the sorted marker set testbench
// -----------------------------------------------------------------------------
package smst_tb_pkg;
  import smst_pkg::*;

  class marker_scoreboard;
    logic [TimeW-1:0] marks[$];        // ascending, no duplicates
    logic [TimeW-1:0] threshold;
    out_t             answers_due[$];  // oldest first
    int               capacity;
    int unsigned      n_errors;
    int unsigned      n_checked;
    int unsigned      n_added;
    int unsigned      n_removed;
    int unsigned      n_refused;

    function new(input int capacity_i);
      capacity  = capacity_i;
      threshold = '0;
      n_errors  = 0;
      n_checked = 0;
      n_added   = 0;
      n_removed = 0;
      n_refused = 0;
    endfunction

    function void set_threshold(input logic [TimeW-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // exact distance, no wrap
    function bit is_near(input logic [TimeW-1:0] mark, input logic [TimeW-1:0] t);
      logic [TimeW-1:0] span;
      span = (mark > t) ? mark - t : t - mark;
      return span <= threshold;
    endfunction

    // lowest index within the threshold, -1 if none
    function int first_near(input logic [TimeW-1:0] t);
      for (int i = 0; i < marks.size(); i++) begin
        if (is_near(marks[i], t)) return i;
      end
      return -1;
    endfunction

    function void note_request(input in_t req);
      out_t answer;
      int   idx;
      int   pos;
      answer = '0;
      case (cmd_e'(req.cmd))
        CMD_TOGGLE: begin
          idx = first_near(req.time_in);
          if (idx >= 0) begin
            marks.delete(idx);
            n_removed++;
          end else if (marks.size() >= capacity) begin
            answer.status = 1'b1;
            n_refused++;
          end else begin
            pos = 0;
            while (pos < marks.size() && marks[pos] < req.time_in) pos++;
            marks.insert(pos, req.time_in);
            answer.hit = 1'b1;
            n_added++;
          end
        end
        CMD_NEAR: begin
          answer.hit = (first_near(req.time_in) >= 0);
        end
        CMD_NEXT: begin
          for (int i = 0; i < marks.size(); i++) begin
            if (marks[i] > req.time_in) begin
              answer.hit       = 1'b1;
              answer.mark_time = marks[i];
              break;
            end
          end
        end
        CMD_PREV: begin
          for (int i = 0; i < marks.size(); i++) begin
            if (marks[i] < req.time_in) begin
              answer.hit       = 1'b1;
              answer.mark_time = marks[i];
            end else begin
              break;
            end
          end
        end
        default: ;
      endcase
      answers_due = {answers_due, answer};
    endfunction

    function void check_result(input out_t got);
      out_t want;
      if (answers_due.size() == 0) begin
        $error("result with no request outstanding: hit %0d mark_time 0x%0h status %0d",
               got.hit, got.mark_time, got.status);
        n_errors++;
        return;
      end
      want = answers_due.pop_front();
      n_checked++;
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        n_errors++;
      end
      if (got.mark_time !== want.mark_time) begin
        $error("mark_time: expected 0x%0h, got 0x%0h", want.mark_time, got.mark_time);
        n_errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        n_errors++;
      end
    endfunction
  endclass

endpackage : smst_tb_pkg

@@ tb/sorted_marker_set_toggle_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sorted_marker_set_toggle_tb
// self-checking bench for the sorted marker set with toggle and lookups
// -----------------------------------------------------------------------------
// A directed opening covers the empty set, the time extremes, duplicate
// removal, first-match removal and the no-wrap distance. Random phases then
// run the set under several snap thresholds (zero, small, large, all ones),
// filling it to capacity so inserts get refused. Every accepted request is
// predicted by a scoreboard and each result is checked field by field.
// -----------------------------------------------------------------------------
module sorted_marker_set_toggle_tb;
  import smst_pkg::*;
  import smst_tb_pkg::*;

  localparam int               MaxMarks      = 64;
  localparam real              ClkPeriod     = 12.0;
  localparam int               ResetCycles   = 6;
  // covers the worst toggle, rounded up
  localparam int               DrainCycles   = 3 * MaxMarks + 40;
  localparam int               HoldOffCycles = 600;
  localparam longint           CycleLimit    = 2_000_000;
  localparam logic [TimeW-1:0] TimeMax       = '1;
  localparam logic [TimeW-1:0] TimeMid       = 48'h8000_0000_0000;

  // all block inputs known from time zero
  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic in_valid   = 1'b0;
  logic in_stall;
  in_t  in_data    = '0;
  logic out_valid;
  logic out_stall  = 1'b0;
  out_t out_data;
  logic             cfg_we    = 1'b0;
  logic [TimeW-1:0] cfg_wdata = '0;

  marker_scoreboard sb;

  // receiver pattern state
  bit          hold_req   = 1'b0;
  int          hold_left  = 0;
  int          stall_mode = 0;
  int          mode_left  = 0;
  int unsigned backpressure_cycles = 0;
  longint      cycle_count = 0;
  int unsigned n_thresholds = 0;

  sorted_marker_set_toggle #(
    .MaxMarks(MaxMarks)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #(ClkPeriod / 2.0) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, sb.pending());
      $display("sorted_marker_set_toggle_tb: done, errors");
      $finish;
    end
  end

  // result side: check what was taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
    // a long hold-off was asked for, counted here in cycles
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
      // block busy and pushing back on the request side
      if (in_valid && in_stall) backpressure_cycles++;
    end else begin
      // stall mode is picked anew when the current one runs out
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic [TimeW-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TimeW-1:0];
  endfunction

  // times spread over the whole range, the ends, and around stored marks
  function automatic logic [TimeW-1:0] pick_time();
    logic [TimeW-1:0] base;
    logic [TimeW-1:0] off;
    int unsigned      sel;
    sel = $urandom_range(0, 9);
    if (sel >= 5 && sb.marks.size() > 0) begin
      base = sb.marks[$urandom_range(0, sb.marks.size() - 1)];
      // offsets straddle the threshold so both sides of the edge get hit
      if (sb.threshold[TimeW-1:30] == '0) begin
        off = TimeW'($urandom_range(0, 32'(sb.threshold[29:0]) * 2 + 2));
      end else begin
        off = rand48() >> $urandom_range(0, TimeW - 1);
      end
      return ($urandom_range(0, 1) == 0) ? base + off : base - off;
    end
    case (sel)
      3:       return TimeW'($urandom_range(0, 4095));
      4:       return TimeMax - TimeW'($urandom_range(0, 4095));
      default: return rand48();
    endcase
  endfunction

  function automatic in_t make_request(input cmd_e c, input logic [TimeW-1:0] t);
    in_t req;
    req.cmd     = c;
    req.time_in = t;
    return req;
  endfunction

  function automatic in_t pick_request(input int toggle_pct);
    cmd_e c;
    if ($urandom_range(0, 99) < toggle_pct) begin
      c = CMD_TOGGLE;
    end else begin
      case ($urandom_range(0, 2))
        0:       c = CMD_NEAR;
        1:       c = CMD_NEXT;
        default: c = CMD_PREV;
      endcase
    end
    return make_request(c, pick_time());
  endfunction

  // offer one request and hold it until taken; valid stays up afterwards
  task automatic send_request(input in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic idle(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // threshold only changes with the block idle
  task automatic write_threshold(input logic [TimeW-1:0] value);
    wait_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_threshold(value);
    n_thresholds++;
  endtask

  task automatic run_directed();
    // empty set: nothing near, nothing before or after
    send_request(make_request(CMD_NEAR, '0));
    send_request(make_request(CMD_NEXT, '0));
    send_request(make_request(CMD_PREV, TimeMax));
    // the two ends and the middle, out of order
    send_request(make_request(CMD_TOGGLE, '0));
    send_request(make_request(CMD_TOGGLE, TimeMax));
    send_request(make_request(CMD_TOGGLE, TimeMid));
    send_request(make_request(CMD_NEXT, '0));
    send_request(make_request(CMD_PREV, TimeMax));
    send_request(make_request(CMD_NEXT, TimeMax));
    send_request(make_request(CMD_PREV, '0));
    send_request(make_request(CMD_NEAR, TimeMax - 1));
    // toggling an equal time removes it
    send_request(make_request(CMD_TOGGLE, TimeMid));
    send_request(make_request(CMD_NEAR, TimeMid));

    write_threshold(48'd16);
    send_request(make_request(CMD_TOGGLE, 48'd1000));
    // inclusive edge of the threshold on both sides
    send_request(make_request(CMD_NEAR, 48'd1016));
    send_request(make_request(CMD_NEAR, 48'd1017));
    send_request(make_request(CMD_NEAR, 48'd984));
    send_request(make_request(CMD_NEAR, 48'd15));
    // drop the top mark, then a query near the top must not wrap to zero
    send_request(make_request(CMD_TOGGLE, TimeMax - 5));
    send_request(make_request(CMD_NEAR, TimeMax - 8));
    send_request(make_request(CMD_TOGGLE, 48'd1010));
    send_request(make_request(CMD_TOGGLE, 48'd10));
    // two marks in reach: the lower one goes
    send_request(make_request(CMD_TOGGLE, 48'd5));
    send_request(make_request(CMD_TOGGLE, 48'd30));
    send_request(make_request(CMD_TOGGLE, 48'd18));
  endtask

  // bursts of requests with random gaps; optional long result hold-off and
  // one full pause for results part way through
  task automatic run_phase(input int n_items, input int toggle_pct,
                           input bit with_hold, input bit with_pause);
    int sent;
    int burst;
    int gap;
    bit held;
    bit paused;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_request(pick_request(toggle_pct));
        sent++;
        if (with_hold && !held && sent >= n_items / 3) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
      end
      if (with_pause && !paused && sent >= n_items / 2) begin
        wait_results();
        paused = 1'b1;
      end else begin
        // a quarter of bursts run straight into the next one
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) idle(gap);
      end
    end
  endtask

  initial begin
    sb = new(MaxMarks);
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // zero threshold: inserts dominate, set fills and refuses
    write_threshold('0);
    run_phase(450, 75, 1'b0, 1'b0);
    // small threshold, mixed traffic, long result hold-off
    write_threshold(TimeW'($urandom_range(1, 1000)));
    run_phase(400, 50, 1'b1, 1'b0);
    // large random threshold, nearly every toggle removes
    write_threshold(rand48() | TimeMid);
    run_phase(250, 50, 1'b0, 1'b1);
    // all ones: every mark is near every time
    write_threshold(TimeMax);
    run_phase(200, 50, 1'b0, 1'b0);
    // tight threshold again, with hold-off and pause
    write_threshold(TimeW'($urandom_range(0, 15)));
    run_phase(450, 65, 1'b1, 1'b1);

    wait_results();
    repeat (DrainCycles) @(posedge clk);

    $display("checked %0d results: %0d marks added, %0d removed, %0d inserts refused on a full set",
             sb.n_checked, sb.n_added, sb.n_removed, sb.n_refused);
    $display("%0d threshold settings used, %0d cycles of request backpressure under hold-off",
             n_thresholds, backpressure_cycles);
    if (sb.n_errors == 0) begin
      $display("sorted_marker_set_toggle_tb: done, clean");
    end else begin
      $display("sorted_marker_set_toggle_tb: done, errors");
    end
    $finish;
  end

endmodule : sorted_marker_set_toggle_tb
